/* rtl/core/rv32_pkg.sv */
package rv32_pkg;

    localparam int MEM_WORDS_DEFAULT = 16384;

    // host operations
    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_MWR   = 2'd1,
        OP_MRD   = 2'd2,
        OP_SETPC = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_OPC   = 3'd1,
        ST_BAD_F3    = 3'd2,
        ST_MIS_LOAD  = 3'd3,
        ST_MIS_STORE = 3'd4,
        ST_MIS_TGT   = 3'd5,
        ST_HALTED    = 3'd6
    } status_t;

    // opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;

    localparam logic [1:0] REG_FETCH_OFFSET = 2'd0;

    // controller -> datapath commands
    typedef struct packed {
        logic take_item;   // latch input item
        logic fetch;       // read instruction word
        logic exec;        // decode, latch instruction, read regs
        logic mem;         // read data word
        logic finish;      // commit and form result
    } rv32_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic is_step;
    } rv32_stat_t;

endpackage

/* rtl/core/rv32_ctrl.sv */
module rv32_ctrl
    import rv32_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  rv32_stat_t stat,
    output rv32_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MEM   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // result register frees once taken
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = stat.is_step ? S_EXEC : S_DONE;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                cmd.mem    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/rv32_dp.sv */
module rv32_dp
    import rv32_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rv32_cmd_t   cmd,
    output rv32_stat_t  stat,
    input  logic [1:0]  operation,
    input  logic [31:0] host_address,
    input  logic [31:0] host_data,
    input  logic [31:0] fetch_offset,
    output logic [2:0]  status,
    output logic [31:0] next_pc,
    output logic [4:0]  dest_register,
    output logic [31:0] dest_value,
    output logic [31:0] read_word
);

    localparam int AW = $clog2(MEM_WORDS);

    // item registers
    op_t         op_reg;
    logic [31:0] haddr_reg, hdata_reg;
    logic [31:0] pc_reg;
    logic        halted_reg;
    logic [31:0] mem_rd_reg;
    logic [31:0] insn_reg, a_reg, b_reg, ea_reg;

    // storage
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rf_reg [1:31];

    // result registers
    logic [2:0]  status_reg;
    logic [4:0]  rd_out_reg;
    logic [31:0] val_out_reg, rword_reg;

    assign stat.is_step = (op_reg == OP_STEP) && !halted_reg;

    // decode fields
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    always_comb
    begin
        opc   = insn_reg[6:0];
        rd    = insn_reg[11:7];
        f3    = insn_reg[14:12];
        rs1   = insn_reg[19:15];
        rs2   = insn_reg[24:20];
        alt   = insn_reg[30];
        imm_i = {{20{insn_reg[31]}}, insn_reg[31:20]};
        imm_s = {{20{insn_reg[31]}}, insn_reg[31:25], insn_reg[11:7]};
        imm_b = {{20{insn_reg[31]}}, insn_reg[7], insn_reg[30:25], insn_reg[11:8], 1'b0};
        imm_u = {insn_reg[31:12], 12'd0};
        imm_j = {{12{insn_reg[31]}}, insn_reg[19:12], insn_reg[20], insn_reg[30:21], 1'b0};
    end

    // memory address selection; the data address is formed in the read cycle
    logic [31:0] fetch_addr;
    logic [31:0] ea_calc;
    logic [AW-1:0] mem_idx;
    always_comb
    begin
        fetch_addr = pc_reg + fetch_offset;
        ea_calc    = a_reg + ((opc == OPC_STORE) ? imm_s : imm_i);
        if (cmd.mem)
            mem_idx = ea_calc[AW+1:2];
        else if (stat.is_step)
            mem_idx = fetch_addr[AW+1:2];
        else
            mem_idx = haddr_reg[AW+1:2];
    end

    // execute and commit logic
    logic        lt_s, lt_u, take;
    logic [31:0] alu_b, alu_res, npc, wval, x, mask, st_data;
    logic [4:0]  sh;
    logic        wr;
    status_t     st;
    always_comb
    begin
        lt_s  = $signed(a_reg) < $signed(b_reg);
        lt_u  = a_reg < b_reg;
        alu_b = (opc == OPC_OP) ? b_reg
              : ((f3 == 3'd1 || f3 == 3'd5) ? {27'd0, insn_reg[24:20]} : imm_i);
        sh    = alu_b[4:0];
        case (f3)
            3'd0: alu_res = (alt && opc == OPC_OP) ? a_reg - alu_b : a_reg + alu_b;
            3'd1: alu_res = a_reg << sh;
            3'd2: alu_res = {31'd0, $signed(a_reg) < $signed(alu_b)};
            3'd3: alu_res = {31'd0, a_reg < alu_b};
            3'd4: alu_res = a_reg ^ alu_b;
            3'd5: alu_res = alt ? 32'($signed(a_reg) >>> sh) : a_reg >> sh;
            3'd6: alu_res = a_reg | alu_b;
            default: alu_res = a_reg & alu_b;
        endcase
        x       = mem_rd_reg >> {ea_reg[1:0], 3'b000};
        st_data = b_reg << {ea_reg[1:0], 3'b000};
        mask    = '0;
        npc     = pc_reg + 32'd4;
        wval    = '0;
        wr      = 1'b0;
        st      = ST_OK;
        take    = 1'b0;
        unique case (opc)
            OPC_LUI:   begin wval = imm_u; wr = 1'b1; end
            OPC_AUIPC: begin wval = pc_reg + imm_u; wr = 1'b1; end
            OPC_JAL:
            begin
                npc = pc_reg + imm_j;
                if (npc[1:0] != 2'd0) st = ST_MIS_TGT;
                wval = pc_reg + 32'd4; wr = 1'b1;
            end
            OPC_JALR:
            begin
                npc = {ea_reg[31:1], 1'b0};
                if (npc[1]) st = ST_MIS_TGT;
                wval = pc_reg + 32'd4; wr = 1'b1;
            end
            OPC_BRANCH:
            begin
                case (f3)
                    3'd0: take = a_reg == b_reg;
                    3'd1: take = a_reg != b_reg;
                    3'd4: take = lt_s;
                    3'd5: take = !lt_s;
                    3'd6: take = lt_u;
                    3'd7: take = !lt_u;
                    default: st = ST_BAD_F3;
                endcase
                if (take)
                begin
                    npc = pc_reg + imm_b;
                    if (npc[1:0] != 2'd0) st = ST_MIS_TGT;
                end
            end
            OPC_LOAD:
            begin
                wr = 1'b1;
                case (f3)
                    3'd0: wval = {{24{x[7]}}, x[7:0]};
                    3'd4: wval = {24'd0, x[7:0]};
                    3'd1, 3'd5:
                    begin
                        if (ea_reg[0]) st = ST_MIS_LOAD;
                        wval = {{16{x[15] & !f3[2]}}, x[15:0]};
                    end
                    3'd2:
                    begin
                        if (ea_reg[1:0] != 2'd0) st = ST_MIS_LOAD;
                        wval = mem_rd_reg;
                    end
                    default: st = ST_BAD_F3;
                endcase
            end
            OPC_STORE:
            begin
                case (f3)
                    3'd0: mask = 32'hFF << {ea_reg[1:0], 3'b000};
                    3'd1:
                    begin
                        if (ea_reg[0]) st = ST_MIS_STORE;
                        mask = 32'hFFFF << {ea_reg[1:0], 3'b000};
                    end
                    3'd2:
                    begin
                        if (ea_reg[1:0] != 2'd0) st = ST_MIS_STORE;
                        mask = 32'hFFFF_FFFF;
                    end
                    default: st = ST_BAD_F3;
                endcase
            end
            OPC_OPIMM, OPC_OP: begin wval = alu_res; wr = 1'b1; end
            OPC_FENCE: ;
            default: st = ST_BAD_OPC;
        endcase
    end

    // single-port memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        mem_rd_reg <= mem[mem_idx];
        if (cmd.take_item && operation == OP_MWR)
            mem[host_address[AW+1:2]] <= host_data;
        else if (cmd.finish && stat.is_step && opc == OPC_STORE && st == ST_OK)
            mem[ea_reg[AW+1:2]] <= (mem_rd_reg & ~mask) | (st_data & mask);
    end

    // item latch, operand read, result
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg    <= op_t'(operation);
            haddr_reg <= host_address;
            hdata_reg <= host_data;
        end
        if (cmd.fetch)
            insn_reg <= '0;
        if (cmd.exec)
        begin
            insn_reg <= mem_rd_reg;
            a_reg    <= (mem_rd_reg[19:15] == 5'd0) ? 32'd0 : rf_reg[mem_rd_reg[19:15]];
            b_reg    <= (mem_rd_reg[24:20] == 5'd0) ? 32'd0 : rf_reg[mem_rd_reg[24:20]];
        end
        if (cmd.mem)
            ea_reg <= ea_calc;
        if (cmd.finish)
        begin
            status_reg  <= ST_OK;
            rd_out_reg  <= '0;
            val_out_reg <= '0;
            rword_reg   <= (op_reg == OP_MRD) ? mem_rd_reg : 32'd0;
            if (op_reg == OP_STEP && halted_reg)
                status_reg <= ST_HALTED;
            else if (stat.is_step)
            begin
                status_reg <= st;
                if (st == ST_OK && wr && rd != 5'd0)
                begin
                    rd_out_reg  <= rd;
                    val_out_reg <= wval;
                end
            end
        end
    end

    // architectural state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            halted_reg <= 1'b0;
            for (int i = 1; i < 32; i++)
                rf_reg[i] <= '0;
        end
        else if (cmd.finish)
        begin
            if (op_reg == OP_SETPC)
            begin
                pc_reg     <= hdata_reg;
                halted_reg <= 1'b0;
            end
            else if (stat.is_step)
            begin
                if (st != ST_OK)
                    halted_reg <= 1'b1;
                else
                begin
                    pc_reg <= npc;
                    if (wr && rd != 5'd0)
                        rf_reg[rd] <= wval;
                end
            end
        end
    end

    assign status        = status_reg;
    assign next_pc       = pc_reg;
    assign dest_register = rd_out_reg;
    assign dest_value    = val_out_reg;
    assign read_word     = rword_reg;

endmodule

/* rtl/core/rv32i_instruction_step.sv */
// RV32I step engine: each input item either executes one instruction at
// pc + fetch_offset, writes or reads one memory word for the host, or sets
// the pc (clearing the halt). One result comes back per item. A step runs
// through fetch read, decode/register read, data read and commit, the two
// reads sharing the single memory port; host operations, and a step while
// halted, skip decode and data read. No new item is taken until the last
// result is formed, and a result that is not taken holds off the next
// item. Any fault halts the engine until the pc is set.
module rv32i_instruction_step
    import rv32_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] host_address,
    input  logic [31:0] host_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] next_pc,
    output logic [4:0]  dest_register,
    output logic [31:0] dest_value,
    output logic [31:0] read_word
);

    logic [31:0] fetch_offset_reg;
    rv32_cmd_t   cmd;
    rv32_stat_t  stat;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FETCH_OFFSET) ? fetch_offset_reg : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fetch_offset_reg <= '0;
        else if (psel && penable && pwrite && paddr == REG_FETCH_OFFSET)
            fetch_offset_reg <= pwdata;
    end

    rv32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rv32_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .host_address  (host_address),
        .host_data     (host_data),
        .fetch_offset  (fetch_offset_reg),
        .status        (status),
        .next_pc       (next_pc),
        .dest_register (dest_register),
        .dest_value    (dest_value),
        .read_word     (read_word)
    );

endmodule
